[hw/rtl/sbh_pkg.sv]
// ----------------------------------------------------------------------------
// sbh_pkg
// shared types and constants for the string bucket hash block
// ----------------------------------------------------------------------------
package sbh_pkg;

    localparam int CHAR_W       = 8;
    localparam int MODE_W       = 2;
    localparam int BUCKET_W     = 17;
    localparam int INDEX_W      = 16;
    localparam int VALUE_W      = 64;
    localparam int DJB_W        = 32;
    localparam int SUM_W        = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = BUCKET_W;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [DJB_W-1:0]    DJB_SEED       = 32'd5381;
    localparam logic [BUCKET_W-1:0] BUCKET_RESET   = 17'd1024;
    localparam logic [BUCKET_W-1:0] BUCKET_MAX     = 17'd65536;
    localparam logic [BUCKET_W-1:0] PARITY_MODULUS = 17'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        HASH_PARITY = 2'd0,
        HASH_SUM    = 2'd1,
        HASH_WORD   = 2'd2,
        HASH_DJB    = 2'd3
    } t_hash_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_DONE = 2'd2
    } t_back_state;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                neg;
        logic [BUCKET_W-1:0] modulus;
    } t_job;

endpackage

[hw/rtl/string_bucket_hash.sv]
// each string end passes the job queue, the modulo unit and the output register
// throughput: one byte per cycle while the job queue is not full; each finished
// string holds the modulo unit through load, 64 one-bit remainder steps and
// result write; the job queue absorbs back-to-back string ends up to its depth
// reset: synchronous active low, restores hash_mode 3, bucket_count 1024, seeds
// ----------------------------------------------------------------------------
// string_bucket_hash
// streaming string hash that maps each string to a bucket index
// ----------------------------------------------------------------------------
module string_bucket_hash
    import sbh_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CHAR_W-1:0]     i_character,
    input  logic                  i_last_char,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [INDEX_W-1:0]    o_bucket_index
);

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    sbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    sbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    sbh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (job_out),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bucket_index (o_bucket_index)
    );

endmodule

[hw/rtl/sbh_front.sv]
// ----------------------------------------------------------------------------
// sbh_front
// byte intake: config registers, running hash accumulators, job issue
// ----------------------------------------------------------------------------
module sbh_front
    import sbh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CHAR_W-1:0]     i_character,
    input  logic                  i_last_char,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    t_hash_mode          r_mode;
    logic [BUCKET_W-1:0] r_bucket;
    logic [DJB_W-1:0]    r_djb,   n_djb;
    logic [SUM_W-1:0]    r_sum,   n_sum;
    logic [VALUE_W-1:0]  r_word,  n_word;
    logic [1:0]          r_pos;
    logic [CHAR_W-1:0]   r_first, n_first;
    logic                r_at_start;
    logic                accept;
    logic [BUCKET_W-1:0] eff_mod;
    logic                parity;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign n_first = r_at_start ? i_character : r_first;
    assign n_djb   = (r_djb << 5) + r_djb + DJB_W'(i_character);
    assign n_sum   = r_sum + SUM_W'(i_character);
    assign n_word  = r_word + (VALUE_W'(i_character) << {r_pos, 3'b000});
    assign parity  = n_first[0] ^ i_character[0];

    always_comb begin
        if (r_bucket == '0) begin
            eff_mod = BUCKET_W'(1);
        end else if (r_bucket > BUCKET_MAX) begin
            eff_mod = BUCKET_MAX;
        end else begin
            eff_mod = r_bucket;
        end
    end

    always_comb begin
        o_job = '0;
        case (r_mode)
            HASH_PARITY: begin
                o_job.value   = VALUE_W'(parity);
                o_job.neg     = 1'b0;
                o_job.modulus = PARITY_MODULUS;
            end
            HASH_SUM: begin
                o_job.value   = VALUE_W'(n_sum);
                o_job.neg     = 1'b0;
                o_job.modulus = eff_mod;
            end
            HASH_WORD: begin
                o_job.value   = n_word;
                o_job.neg     = n_word[VALUE_W-1];
                o_job.modulus = eff_mod;
            end
            default: begin
                o_job.value   = {{(VALUE_W-DJB_W){n_djb[DJB_W-1]}}, n_djb};
                o_job.neg     = n_djb[DJB_W-1];
                o_job.modulus = eff_mod;
            end
        endcase
    end

    assign o_push = accept && i_last_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= HASH_DJB;
            r_bucket   <= BUCKET_RESET;
            r_djb      <= DJB_SEED;
            r_sum      <= '0;
            r_word     <= '0;
            r_pos      <= '0;
            r_first    <= '0;
            r_at_start <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HASH_MODE) begin
                    r_mode <= t_hash_mode'(i_cfg_data[MODE_W-1:0]);
                end else begin
                    r_bucket <= i_cfg_data;
                end
            end
            if (accept) begin
                if (i_last_char) begin
                    r_djb      <= DJB_SEED;
                    r_sum      <= '0;
                    r_word     <= '0;
                    r_pos      <= '0;
                    r_first    <= '0;
                    r_at_start <= 1'b1;
                end else begin
                    r_djb      <= n_djb;
                    r_sum      <= n_sum;
                    r_word     <= n_word;
                    r_pos      <= r_pos + 2'd1;
                    r_first    <= n_first;
                    r_at_start <= 1'b0;
                end
            end
        end
    end

endmodule

[hw/rtl/sbh_queue.sv]
// ----------------------------------------------------------------------------
// sbh_queue
// short job fifo between the byte intake and the modulo unit
// ----------------------------------------------------------------------------
module sbh_queue
    import sbh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/sbh_back.sv]
// ----------------------------------------------------------------------------
// sbh_back
// magnitude and bit-serial modulo of one job, with output register
// ----------------------------------------------------------------------------
module sbh_back
    import sbh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [INDEX_W-1:0] o_bucket_index
);

    localparam int STEP_W = $clog2(VALUE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

    t_back_state         r_state, n_state;
    logic [VALUE_W-1:0]  r_dividend;
    logic [BUCKET_W-1:0] r_modulus;
    logic [BUCKET_W-1:0] r_rem;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic                slot_free;
    logic                load;
    logic                shift;
    logic                write_out;
    logic [BUCKET_W:0]   trial;
    logic [BUCKET_W:0]   trial_sub;
    logic [BUCKET_W-1:0] n_rem;

    assign slot_free = !r_out_valid || i_ready;
    assign trial     = {r_rem, r_dividend[VALUE_W-1]};
    assign trial_sub = trial - {1'b0, r_modulus};
    assign n_rem     = (trial >= {1'b0, r_modulus}) ? trial_sub[BUCKET_W-1:0]
                                                    : trial[BUCKET_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        load      = 1'b0;
        shift     = 1'b0;
        write_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                load = !i_empty;
            end
            ST_DIV: begin
                shift = 1'b1;
            end
            ST_DONE: begin
                write_out = slot_free;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign o_pop          = load;
    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_out_index;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dividend <= i_job.neg ? (VALUE_W'(0) - i_job.value) : i_job.value;
            r_modulus  <= i_job.modulus;
            r_rem      <= '0;
        end else if (shift) begin
            r_dividend <= {r_dividend[VALUE_W-2:0], 1'b0};
            r_rem      <= n_rem;
        end
        if (write_out) begin
            r_out_index <= r_rem[INDEX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_step <= '0;
            end else if (shift) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (write_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/sbh_checker.sv]
// ----------------------------------------------------------------------------
// sbh_checker
// port-level checks for the string bucket hash block
// ----------------------------------------------------------------------------
module sbh_checker
    import sbh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  logic                  i_last_char,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  logic [INDEX_W-1:0]    o_bucket_index
);

    logic [MODE_W-1:0]   r_mode;
    logic [BUCKET_W-1:0] r_bucket;
    logic [BUCKET_W-1:0] limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_W'(HASH_DJB);
            r_bucket <= BUCKET_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_HASH_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end else begin
                r_bucket <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_mode == MODE_W'(HASH_PARITY)) begin
            limit = PARITY_MODULUS;
        end else if (r_bucket == '0) begin
            limit = BUCKET_W'(1);
        end else if (r_bucket > BUCKET_MAX) begin
            limit = BUCKET_MAX;
        end else begin
            limit = r_bucket;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bucket_index))
        else $error("stalled result changed or dropped");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_bucket_index} < limit))
        else $error("bucket index outside modulus");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid && o_ready && i_last_char))
        else $error("input ready dropped without a string end");

endmodule

bind string_bucket_hash sbh_checker u_sbh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_index    (i_cfg_index),
    .i_cfg_data     (i_cfg_data),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_last_char    (i_last_char),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_bucket_index (o_bucket_index)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for string_bucket_hash: streams strings byte by byte
// under random flow control, predicts every bucket index from a local copy
// of the four hash accumulators and checks each result transaction in order
// ----------------------------------------------------------------------------
module tb;
    import sbh_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 165;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_HASH_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [CHAR_W-1:0]     i_character = '0;
    logic                  i_last_char = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [INDEX_W-1:0]    o_bucket_index;

    // configuration mirror
    t_hash_mode          cur_mode = HASH_DJB;
    logic [BUCKET_W-1:0] cur_buckets = BUCKET_RESET;

    // hash accumulators of the string in flight
    logic [DJB_W-1:0]   djb_acc = DJB_SEED;
    logic [SUM_W-1:0]   char_sum = '0;
    logic [VALUE_W-1:0] word_sum = '0;
    logic [1:0]         word_pos = '0;
    logic [CHAR_W-1:0]  head_char = '0;
    logic               at_head = 1'b1;

    logic [INDEX_W-1:0] bucket_q[$];
    int                 err_cnt = 0;
    bit                 no_gaps = 1'b0;
    int                 hold_left = 0;

    string_bucket_hash u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_character    (i_character),
        .i_last_char    (i_last_char),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bucket_index (o_bucket_index)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hff;
        if (r < 50) return CHAR_W'($urandom_range(32, 126));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 16);
        return $urandom_range(17, 64);
    endfunction

    // advance all accumulators by one byte, queue the bucket on the final byte
    task automatic absorb_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        logic [VALUE_W-1:0]  mag64;
        logic [DJB_W-1:0]    mag32;
        logic [BUCKET_W-1:0] modulus;
        logic [INDEX_W-1:0]  idx;
        if (at_head) begin
            head_char = ch;
            at_head = 1'b0;
        end
        djb_acc = djb_acc * 32'd33 + {24'b0, ch};
        char_sum = char_sum + {24'b0, ch};
        word_sum = word_sum + ({56'b0, ch} << (8 * word_pos));
        word_pos = word_pos + 2'd1;
        if (is_last) begin
            if (cur_buckets == '0) modulus = 17'd1;
            else if (cur_buckets > BUCKET_MAX) modulus = BUCKET_MAX;
            else modulus = cur_buckets;
            case (cur_mode)
                HASH_PARITY: idx = {15'b0, head_char[0] ^ ch[0]};
                HASH_SUM: idx = INDEX_W'({32'b0, char_sum} % {47'b0, modulus});
                HASH_WORD: begin
                    mag64 = word_sum[VALUE_W-1] ? (~word_sum + 64'd1) : word_sum;
                    idx = INDEX_W'(mag64 % {47'b0, modulus});
                end
                default: begin
                    mag32 = djb_acc[DJB_W-1] ? (~djb_acc + 32'd1) : djb_acc;
                    idx = INDEX_W'({32'b0, mag32} % {47'b0, modulus});
                end
            endcase
            bucket_q.push_back(idx);
            djb_acc = DJB_SEED;
            char_sum = '0;
            word_sum = '0;
            word_pos = '0;
            head_char = '0;
            at_head = 1'b1;
        end
    endtask

    // one input transaction; returns at the accepting edge with valid still high
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_character <= ch;
        i_last_char <= is_last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_char(ch, is_last);
    endtask

    task automatic send_string(input int len);
        for (int k = 0; k < len; k++) send_char(rand_char(), k == len - 1);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (bucket_q.size() != 0) @(posedge i_clk);
    endtask

    // wait for every expected result, then let the block sit idle before going on
    task automatic drain_and_settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HASH_MODE) cur_mode = t_hash_mode'(data[MODE_W-1:0]);
        else cur_buckets = data[BUCKET_W-1:0];
    endtask

    task automatic set_mode(input t_hash_mode mode);
        logic [CFG_DATA_W-1:0] data;
        // junk in the upper bits must be ignored
        data = CFG_DATA_W'($urandom());
        data[MODE_W-1:0] = mode;
        write_reg(CFG_HASH_MODE, data);
    endtask

    task automatic set_buckets(input logic [BUCKET_W-1:0] count);
        write_reg(CFG_BUCKET_COUNT, count);
    endtask

    task automatic test_reset_defaults();
        send_char("a", 1'b0);
        send_char("b", 1'b1);
        send_char(8'hff, 1'b1);
        drain_and_settle();
    endtask

    task automatic test_each_mode();
        set_mode(HASH_PARITY);
        set_buckets(17'd3);
        send_char(8'h01, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b1);
        drain_and_settle();
        set_mode(HASH_SUM);
        set_buckets(BUCKET_MAX);
        send_char(8'hff, 1'b0);
        send_char(8'hff, 1'b1);
        drain_and_settle();
        set_mode(HASH_WORD);
        for (int k = 0; k < 8; k++) send_char(8'hff, k == 7);
        drain_and_settle();
    endtask

    task automatic test_bucket_limits();
        set_mode(HASH_SUM);
        set_buckets(17'd0);
        send_char(8'hff, 1'b1);
        drain_and_settle();
        set_mode(HASH_DJB);
        set_buckets(17'h1ffff);
        send_char(8'h7f, 1'b0);
        send_char(8'h80, 1'b1);
        drain_and_settle();
    endtask

    task automatic test_mode_switch_midstring();
        set_mode(HASH_SUM);
        set_buckets(17'd1000);
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        drain_and_settle();
        set_mode(HASH_WORD);
        send_char("c", 1'b1);
        drain_and_settle();
    endtask

    task automatic test_random_streams();
        int sent;
        int len;
        bit paused;
        for (int phase = 0; phase < 8; phase++) begin
            drain_and_settle();
            case (phase)
                0: begin set_mode(HASH_PARITY); set_buckets(BUCKET_W'($urandom_range(1, 131071))); end
                1: begin set_mode(HASH_SUM);    set_buckets(17'd1); end
                2: begin set_mode(HASH_WORD);   set_buckets(BUCKET_MAX); end
                3: begin set_mode(HASH_DJB);    set_buckets(17'd0); end
                4: begin set_mode(HASH_DJB);    set_buckets(17'h1ffff); end
                5: begin set_mode(HASH_SUM);    set_buckets(BUCKET_W'($urandom_range(2, 65536))); end
                6: begin set_mode(HASH_WORD);   set_buckets(BUCKET_W'($urandom_range(1, 1000))); end
                default: begin
                    set_mode(t_hash_mode'($urandom_range(0, 3)));
                    set_buckets(BUCKET_W'($urandom()));
                end
            endcase
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                // back-to-back stretch with no flow control gaps
                no_gaps = (sent >= 40 && sent < 70);
                if (!paused && sent >= 100) begin
                    wait_results();
                    paused = 1'b1;
                end
                len = pick_len();
                send_string(len);
                sent += len;
            end
            no_gaps = 1'b0;
        end
    endtask

    // result side: random stalls and in-order check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (bucket_q.size() == 0) begin
                $error("bucket_index: no transaction expected, actual %0d", o_bucket_index);
                err_cnt++;
            end else begin
                if (o_bucket_index !== bucket_q[0]) begin
                    $error("bucket_index mismatch: expected %0d, actual %0d",
                           bucket_q[0], o_bucket_index);
                    err_cnt++;
                end
                void'(bucket_q.pop_front());
            end
        end
        if (hold_left == 0 && !no_gaps && $urandom_range(0, 99) < 25) hold_left = pick_gap();
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        int guard;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_each_mode();
        test_bucket_limits();
        test_mode_switch_midstring();
        test_random_streams();
        i_valid <= 1'b0;
        guard = 0;
        @(posedge i_clk);
        while (bucket_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (bucket_q.size() != 0) begin
            $error("bucket_index: %0d transactions never arrived", bucket_q.size());
            err_cnt++;
        end
        repeat (SETTLE_CYCLES + 20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sbh_pkg.sv
hw/rtl/sbh_front.sv
hw/rtl/sbh_queue.sv
hw/rtl/sbh_back.sv
hw/rtl/string_bucket_hash.sv
hw/rtl/sbh_checker.sv
tb/sv/tb.sv
